>>> rtl/ring_vertex_angle_check_core_defines.svh
// assertion macros for the ring vertex angle check
`ifndef RING_VERTEX_ANGLE_CHECK_CORE_DEFINES_SVH
`define RING_VERTEX_ANGLE_CHECK_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RVAC_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("assertion failed");
`define RVAC_ASSERT_NR(label, clk_sig, prop) \
    label: assert property (@(posedge clk_sig) prop) else $error("assertion failed");
`else
`define RVAC_ASSERT(label, clk_sig, rst_sig, prop)
`define RVAC_ASSERT_NR(label, clk_sig, prop)
`endif
`endif

>>> rtl/rvac_pkg.sv
// shared constants and types of the ring vertex angle check
package rvac_pkg;
    localparam int COORD_BITS = 16;
    localparam int INDEX_BITS = 16;
    localparam int COS_BITS   = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int MAG_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * MAG_BITS;
    localparam int LEN_BITS   = PROD_BITS + 1;
    localparam int DOT_BITS   = PROD_BITS + 1;
    localparam int CMAG_BITS  = COS_BITS;
    localparam int CSQ_BITS   = 2 * CMAG_BITS;
    localparam int RHS_BITS   = CSQ_BITS + 2 * LEN_BITS;
    localparam int LHS_BITS   = 2 * DOT_BITS + 28;
    localparam int WIDE_BITS  = (RHS_BITS > LHS_BITS) ? RHS_BITS : LHS_BITS;
    localparam int CNT_BITS   = INDEX_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic sharp;
        logic zero;
    } vflag_t;
endpackage

>>> rtl/rvac_vertex_unit.sv
// bit-serial angle test of one vertex against its two neighbours
`include "ring_vertex_angle_check_core_defines.svh"
module rvac_vertex_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [rvac_pkg::COORD_BITS-1:0] px,
    input  logic signed [rvac_pkg::COORD_BITS-1:0] py,
    input  logic signed [rvac_pkg::COORD_BITS-1:0] vx,
    input  logic signed [rvac_pkg::COORD_BITS-1:0] vy,
    input  logic signed [rvac_pkg::COORD_BITS-1:0] nx,
    input  logic signed [rvac_pkg::COORD_BITS-1:0] ny,
    input  logic signed [rvac_pkg::COS_BITS-1:0]   cosine,
    output logic                                   busy,
    output logic                                   done,
    output rvac_pkg::vflag_t                       flags
);
    import rvac_pkg::*;

    // shift-add multiplier: multiplicand << step, multiplier bit-serial
    localparam logic [3:0] OP_AXBX = 4'd0;
    localparam logic [3:0] OP_AYBY = 4'd1;
    localparam logic [3:0] OP_AXAX = 4'd2;
    localparam logic [3:0] OP_AYAY = 4'd3;
    localparam logic [3:0] OP_BXBX = 4'd4;
    localparam logic [3:0] OP_BYBY = 4'd5;
    localparam logic [3:0] OP_DD   = 4'd6;
    localparam logic [3:0] OP_CC   = 4'd7;
    localparam logic [3:0] OP_CLA  = 4'd8;
    localparam logic [3:0] OP_CLB  = 4'd9;
    localparam logic [3:0] OP_FIN  = 4'd10;

    logic [MAG_BITS-1:0] axm_reg, aym_reg, bxm_reg, bym_reg;
    logic                axn_reg, ayn_reg, bxn_reg, byn_reg;
    logic [LEN_BITS-1:0] la_reg, lb_reg;
    logic [PROD_BITS-1:0] p1_reg, p2_reg;
    logic [WIDE_BITS-1:0] acc_reg, acc_next, mcand_reg, mcand_next;
    logic [WIDE_BITS-1:0] mplier_reg, mplier_next;
    logic [WIDE_BITS-1:0] lhs_reg;
    logic [3:0]          op_reg, op_next;
    logic                run_reg, run_next;
    logic                done_reg;
    vflag_t              flags_reg;
    logic signed [COS_BITS-1:0] cos_reg;

    logic signed [DIFF_BITS-1:0] ax, ay, bx, by;
    assign ax = DIFF_BITS'(px) - DIFF_BITS'(vx);
    assign ay = DIFF_BITS'(py) - DIFF_BITS'(vy);
    assign bx = DIFF_BITS'(nx) - DIFF_BITS'(vx);
    assign by = DIFF_BITS'(ny) - DIFF_BITS'(vy);

    function automatic logic [MAG_BITS-1:0] mag_of(input logic signed [DIFF_BITS-1:0] v);
        mag_of = v[DIFF_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
    endfunction

    logic [COS_BITS-1:0] cmag;
    assign cmag = cos_reg[COS_BITS-1] ? COS_BITS'(-cos_reg) : COS_BITS'(cos_reg);

    logic mult_last;
    assign mult_last = (mplier_reg == '0);

    // signed dot product from partial products
    logic n1, n2, dneg, dpos;
    logic [DOT_BITS-1:0] dmag_c;
    always_comb
    begin
        n1 = axn_reg ^ bxn_reg;
        n2 = ayn_reg ^ byn_reg;
        if (n1 == n2)
        begin
            dmag_c = DOT_BITS'(p1_reg) + DOT_BITS'(p2_reg);
            dneg   = n1;
        end
        else if (p1_reg >= p2_reg)
        begin
            dmag_c = DOT_BITS'(p1_reg - p2_reg);
            dneg   = n1;
        end
        else
        begin
            dmag_c = DOT_BITS'(p2_reg - p1_reg);
            dneg   = n2;
        end
        dpos = (dmag_c != '0) && !dneg;
    end

    logic lz, gt, lt;
    assign lz = (la_reg == '0) || (lb_reg == '0);
    assign gt = lhs_reg > acc_reg;
    assign lt = lhs_reg < acc_reg;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        op_next     = op_reg;
        run_next    = run_reg;
        if (run_reg && op_reg != OP_FIN)
        begin
            if (!mult_last)
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
            else
            begin
                op_next  = op_reg + 4'd1;
                acc_next = '0;
                unique case (op_reg)
                    OP_AXBX: begin mcand_next = WIDE_BITS'(bym_reg); mplier_next = WIDE_BITS'(aym_reg); end
                    OP_AYBY: begin mcand_next = WIDE_BITS'(axm_reg); mplier_next = WIDE_BITS'(axm_reg); end
                    OP_AXAX: begin mcand_next = WIDE_BITS'(aym_reg); mplier_next = WIDE_BITS'(aym_reg); end
                    OP_AYAY: begin mcand_next = WIDE_BITS'(bxm_reg); mplier_next = WIDE_BITS'(bxm_reg); end
                    OP_BXBX: begin mcand_next = WIDE_BITS'(bym_reg); mplier_next = WIDE_BITS'(bym_reg); end
                    OP_BYBY: begin mcand_next = WIDE_BITS'(dmag_c) << 28; mplier_next = WIDE_BITS'(dmag_c); end
                    OP_DD:   begin mcand_next = WIDE_BITS'(cmag); mplier_next = WIDE_BITS'(cmag); end
                    OP_CC:   begin mcand_next = acc_reg; mplier_next = WIDE_BITS'(la_reg); end
                    OP_CLA:  begin mcand_next = acc_reg; mplier_next = WIDE_BITS'(lb_reg); end
                    OP_CLB:  begin acc_next = acc_reg; mplier_next = '0; end
                    default: begin mplier_next = '0; end
                endcase
            end
        end
        else if (run_reg)
            run_next = 1'b0;
        if (start)
        begin
            run_next    = 1'b1;
            op_next     = OP_AXBX;
            acc_next    = '0;
            mcand_next  = WIDE_BITS'(mag_of(bx));
            mplier_next = WIDE_BITS'(mag_of(ax));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_AXBX;
        end
        else
        begin
            run_reg  <= run_next;
            op_reg   <= op_next;
            done_reg <= run_reg && op_reg == OP_FIN;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        if (start)
        begin
            axm_reg <= mag_of(ax); aym_reg <= mag_of(ay);
            bxm_reg <= mag_of(bx); bym_reg <= mag_of(by);
            axn_reg <= ax[DIFF_BITS-1]; ayn_reg <= ay[DIFF_BITS-1];
            bxn_reg <= bx[DIFF_BITS-1]; byn_reg <= by[DIFF_BITS-1];
            cos_reg <= cosine;
        end
        if (run_reg && mult_last)
        begin
            unique case (op_reg)
                OP_AXBX: p1_reg <= PROD_BITS'(acc_reg);
                OP_AYBY: p2_reg <= PROD_BITS'(acc_reg);
                OP_AXAX: la_reg <= LEN_BITS'(acc_reg);
                OP_AYAY: la_reg <= la_reg + LEN_BITS'(acc_reg);
                OP_BXBX: lb_reg <= LEN_BITS'(acc_reg);
                OP_BYBY: lb_reg <= lb_reg + LEN_BITS'(acc_reg);
                OP_DD:   lhs_reg <= acc_reg;
                default: ;
            endcase
        end
        if (run_reg && op_reg == OP_FIN)
        begin
            flags_reg.zero  <= lz;
            if (lz)
                flags_reg.sharp <= 1'b0;
            else if (!cos_reg[COS_BITS-1] && cos_reg != '0)
                flags_reg.sharp <= dpos && gt;
            else if (cos_reg == '0)
                flags_reg.sharp <= dpos;
            else if (!dneg || dmag_c == '0)
                flags_reg.sharp <= 1'b1;
            else
                flags_reg.sharp <= lt;
        end
    end

    assign busy  = run_reg;
    assign done  = done_reg;
    assign flags = flags_reg;

    `RVAC_ASSERT(a_no_start_busy, clk, rst_n, start |-> !run_reg)
    `RVAC_ASSERT(a_done_after_fin, clk, rst_n, done_reg |-> !run_reg)
    `RVAC_ASSERT(a_start_runs, clk, rst_n, start |=> run_reg)
endmodule

>>> rtl/ring_vertex_angle_check_core.sv
// ring vertex minimum-angle check, top level
// Vertices are taken one at a time: stall stays high from the accepting edge until every
// result of that vertex is loaded into the output register. A vertex that only fills the
// ring history goes straight to the emit state; one that closes a ring of fewer than three
// vertices first waits for a free output register. Every other result comes from a vertex
// check on one shift-add multiplier that consumes one multiplier bit per cycle over ten
// products; the length of a check is set by the bit lengths of the edge vectors, the dot
// product, the squared lengths and the cosine. A vertex that closes a ring runs three
// checks; results wait in the output register while the next check proceeds, and a
// receiver still stalling it when the next result is ready adds its stall time.
`include "ring_vertex_angle_check_core_defines.svh"
module ring_vertex_angle_check_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [rvac_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [rvac_pkg::COORD_BITS-1:0] point_y,
    input  logic                                   ring_end,
    input  logic                                   valid,
    output logic                                   stall,
    output logic [rvac_pkg::INDEX_BITS-1:0]        vertex_index,
    output logic                                   small_angle,
    output logic                                   zero_length,
    output logic                                   short_ring,
    output logic                                   run_last,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic signed [rvac_pkg::COS_BITS-1:0]   cfg_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready
);
    import rvac_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHK   = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_SHORT = 3'd4;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    logic [2:0] state_reg;
    logic [1:0] job_reg;
    logic [1:0] njobs_reg;
    logic       end_reg;
    logic [CNT_BITS-1:0] count_reg;
    coord_t first_x_reg, first_y_reg, second_x_reg, second_y_reg;
    coord_t older_x_reg, older_y_reg, recent_x_reg, recent_y_reg;
    coord_t cur_x_reg, cur_y_reg;
    logic signed [COS_BITS-1:0] cos_reg;

    logic [INDEX_BITS-1:0] oidx_reg;
    logic osmall_reg, ozero_reg, oshort_reg, olast_reg, ovalid_reg;

    logic   start, busy, done, accept, out_free;
    vflag_t flags;
    coord_t px, py, vx, vy, nx, ny;

    // done is a single-cycle pulse; hold flags until the output register frees
    logic   pend_reg;
    vflag_t pflags_reg;

    // completion handling honoring a held result
    logic fin_ok;
    assign fin_ok = (done || pend_reg) && out_free;

    assign accept   = valid && !stall;
    assign out_free = !ovalid_reg || !out_stall;
    assign stall    = state_reg != ST_IDLE;
    assign cfg_ready = state_reg == ST_IDLE;

    always_comb
    begin
        case (job_reg)
            2'd0:    begin px = older_x_reg;  py = older_y_reg;  vx = recent_x_reg;
                           vy = recent_y_reg; nx = cur_x_reg;    ny = cur_y_reg; end
            2'd1:    begin px = recent_x_reg; py = recent_y_reg; vx = cur_x_reg;
                           vy = cur_y_reg;    nx = first_x_reg;  ny = first_y_reg; end
            default: begin px = cur_x_reg;    py = cur_y_reg;    vx = first_x_reg;
                           vy = first_y_reg;  nx = second_x_reg; ny = second_y_reg; end
        endcase
    end

    assign start = state_reg == ST_CHK;

    rvac_vertex_unit u_unit (
        .clk(clk), .rst_n(rst_n), .start(start),
        .px(px), .py(py), .vx(vx), .vy(vy), .nx(nx), .ny(ny),
        .cosine(cos_reg), .busy(busy), .done(done), .flags(flags)
    );

    logic [INDEX_BITS-1:0] cnt_idx, job_idx;
    assign cnt_idx = count_reg[INDEX_BITS-1:0];
    always_comb
    begin
        case (job_reg)
            2'd0:    job_idx = cnt_idx - INDEX_BITS'(1);
            2'd1:    job_idx = cnt_idx;
            default: job_idx = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            count_reg  <= '0;
            cos_reg    <= COS_BITS'(16384);
            job_reg    <= '0;
            njobs_reg  <= '0;
            end_reg    <= 1'b0;
            first_x_reg <= '0; first_y_reg <= '0; second_x_reg <= '0; second_y_reg <= '0;
            older_x_reg <= '0; older_y_reg <= '0; recent_x_reg <= '0; recent_y_reg <= '0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                cos_reg <= cfg_data;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        end_reg <= ring_end;
                        if (ring_end && count_reg < CNT_BITS'(2))
                            state_reg <= ST_SHORT;
                        else if (count_reg >= CNT_BITS'(2))
                        begin
                            job_reg   <= 2'd0;
                            njobs_reg <= ring_end ? 2'd2 : 2'd0;
                            state_reg <= ST_CHK;
                        end
                        else
                            state_reg <= ST_EMIT;
                    end
                end
                ST_CHK:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (fin_ok)
                    begin
                        ovalid_reg <= 1'b1;
                        if (job_reg == njobs_reg)
                            state_reg <= ST_EMIT;
                        else
                        begin
                            job_reg   <= job_reg + 2'd1;
                            state_reg <= ST_CHK;
                        end
                    end
                end
                ST_SHORT:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // ring bookkeeping once all results are out
                    if (end_reg)
                        count_reg <= '0;
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            first_x_reg <= cur_x_reg; first_y_reg <= cur_y_reg;
                        end
                        else if (count_reg == CNT_BITS'(1))
                        begin
                            second_x_reg <= cur_x_reg; second_y_reg <= cur_y_reg;
                        end
                        older_x_reg  <= recent_x_reg; older_y_reg <= recent_y_reg;
                        recent_x_reg <= cur_x_reg;    recent_y_reg <= cur_y_reg;
                        if (count_reg != CNT_MAX)
                            count_reg <= count_reg + CNT_BITS'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg <= point_x;
            cur_y_reg <= point_y;
        end
        if (done)
            pflags_reg <= flags;
        if (state_reg == ST_WAIT && fin_ok)
        begin
            oidx_reg   <= job_idx;
            osmall_reg <= done ? flags.sharp : pflags_reg.sharp;
            ozero_reg  <= done ? flags.zero : pflags_reg.zero;
            oshort_reg <= 1'b0;
            olast_reg  <= job_reg == 2'd2;
        end
        if (state_reg == ST_SHORT && out_free)
        begin
            oidx_reg   <= '0;
            osmall_reg <= 1'b0;
            ozero_reg  <= 1'b0;
            oshort_reg <= 1'b1;
            olast_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (state_reg != ST_WAIT)
            pend_reg <= 1'b0;
        else if (done && !out_free)
            pend_reg <= 1'b1;
    end

    assign vertex_index = oidx_reg;
    assign small_angle  = osmall_reg;
    assign zero_length  = ozero_reg;
    assign short_ring   = oshort_reg;
    assign run_last     = olast_reg;
    assign out_valid    = ovalid_reg;

    `RVAC_ASSERT(a_out_hold, clk, rst_n, (ovalid_reg && out_stall) |=> ovalid_reg)
    `RVAC_ASSERT(a_wait_unit, clk, rst_n, (state_reg == ST_CHK) |=> busy)
    `RVAC_ASSERT(a_short_zero, clk, rst_n, (ovalid_reg && oshort_reg) |-> (oidx_reg == '0 && olast_reg))
    `RVAC_ASSERT(a_fin_free, clk, rst_n, (state_reg == ST_WAIT && fin_ok) |-> out_free)
endmodule
